### hdl/cps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and constants of the point snap engine.
// ----------------------------------------------------------------------------
package cps_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_POINT   = 2'd1,
    OP_SEGMENT = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_END  = 2'd1,
    KIND_MID  = 2'd2,
    KIND_SEG  = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic [1:0] REG_SNAP_EN  = 2'd0;
  localparam logic [1:0] REG_GRID_EN  = 2'd1;
  localparam logic [1:0] REG_GRID_SP  = 2'd2;
  localparam logic [1:0] REG_TOL      = 2'd3;

  localparam int CFG_AW = 4;

  localparam logic [30:0] GRID_SP_RST = 31'd65536;
  localparam logic [30:0] TOL_RST     = 31'd655360;

  // bit-serial multiply and restoring divide step counts
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 34;

endpackage

### hdl/cps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cps_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/cad_point_snap_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cad_point_snap_engine
// Point and segment tables with nearest-snap cursor queries, Q16.16.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+---------------------------
//  input    | in_op, in_first_*, in_second_*, in_cursor_* | start & !busy
//  result   | out_snap_x/y, out_snap_kind, out_status | out_valid, one cycle
//  config   | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
//  Clear and loads: result in the cycle after the item is taken.
//  Query with snapping on: a scan of the points and segment vertices; when that
//  finds nothing, a projection pass, using the 32-step shift-add multiply and
//  34-step divide per axis; when still nothing, grid rounding if enabled.
//  busy stays high meanwhile.
//  Reset is synchronous; tables empty after reset, no clearing pass.
// ----------------------------------------------------------------------------
module cad_point_snap_engine #(
  parameter int MAX_POINTS   = 64,
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic signed [31:0]          in_first_x,
  input  logic signed [31:0]          in_first_y,
  input  logic signed [31:0]          in_second_x,
  input  logic signed [31:0]          in_second_y,
  input  logic signed [31:0]          in_cursor_x,
  input  logic signed [31:0]          in_cursor_y,
  output logic                        out_valid,
  output logic signed [31:0]          out_snap_x,
  output logic signed [31:0]          out_snap_y,
  output logic [1:0]                  out_snap_kind,
  output logic                        out_status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cps_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cps_pkg::*;

  localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int SCW = $clog2(MAX_SEGMENTS + 1);
  localparam int IW  = (PCW > SCW) ? PCW : SCW;

  typedef enum logic [5:0] {
    IDLE, Q_TOL, Q_BEST,
    P_RD, P_LD,
    S1_RD, S1_LD, S1_B, S1_M,
    S2_RD, S2_LD, S2_M0, S2_M1, S2_M2, S2_M3, S2_M4, S2_DEC,
    PJ_INIT, PJ_MUL, PJ_DIV, PJ_FIN, DV_STEP,
    G_SET, G_MUL, G_SAT,
    T_DIF, T_SQX, T_SQY, T_CMP,
    FIN
  } state_t;

  state_t state_r, ret_r, div_ret_r;

  logic              snap_en_r, grid_en_r;
  logic [30:0]       grid_sp_r, tol_r;
  logic [PCW-1:0]    pcount_r;
  logic [SCW-1:0]    scount_r;
  logic [IW-1:0]     idx_r;

  logic signed [31:0] cx_r, cy_r, ax_r, ay_r, bx_r, by_r;
  logic signed [32:0] dx_r, dy_r, ex_r, ey_r;
  logic signed [31:0] cand_x_r, cand_y_r, res_x_r, res_y_r;
  kind_t              cand_kind_r, res_kind_r;
  logic [63:0]        best_r, sqx_r;
  logic [32:0]        magx_r, magy_r;
  logic               rej_r;
  logic signed [65:0] prod_r;
  logic signed [67:0] n_r, den_r;
  logic [99:0]        pacc_r;
  logic [31:0]        dmag_r;
  logic [33:0]        num_sh_r, quo_r;
  logic [67:0]        rem_r, div_r;
  logic [5:0]         cnt_r;
  logic               axis_r;

  logic               out_valid_r, out_status_r;
  logic signed [31:0] out_x_r, out_y_r;
  kind_t              out_kind_r;

  // table RAMs
  logic        pt_we, seg_we;
  logic [63:0] pt_rdata, ss_rdata, se_rdata;
  logic        pfull, sfull;

  assign pfull  = pcount_r >= PCW'(MAX_POINTS);
  assign sfull  = scount_r >= SCW'(MAX_SEGMENTS);
  assign pt_we  = (state_r == IDLE) && start && (op_t'(in_op) == OP_POINT) && !pfull;
  assign seg_we = (state_r == IDLE) && start && (op_t'(in_op) == OP_SEGMENT) && !sfull;

  cps_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(pcount_r[PAW-1:0]),
    .wdata({in_first_x, in_first_y}), .raddr(idx_r[PAW-1:0]), .rdata(pt_rdata)
  );
  cps_ram #(.WIDTH(64), .DEPTH(MAX_SEGMENTS)) u_ss_ram (
    .clk(clk), .we(seg_we), .waddr(scount_r[SAW-1:0]),
    .wdata({in_first_x, in_first_y}), .raddr(idx_r[SAW-1:0]), .rdata(ss_rdata)
  );
  cps_ram #(.WIDTH(64), .DEPTH(MAX_SEGMENTS)) u_se_ram (
    .clk(clk), .we(seg_we), .waddr(scount_r[SAW-1:0]),
    .wdata({in_second_x, in_second_y}), .raddr(idx_r[SAW-1:0]), .rdata(se_rdata)
  );

  logic signed [31:0] sa_x, sa_y, sb_x, sb_y;
  assign sa_x = ss_rdata[63:32];
  assign sa_y = ss_rdata[31:0];
  assign sb_x = se_rdata[63:32];
  assign sb_y = se_rdata[31:0];

  // shared multiplier operand select
  logic signed [32:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      Q_TOL: begin
        mul_a = {2'b00, tol_r};
        mul_b = {2'b00, tol_r};
      end
      T_SQX: begin
        mul_a = magx_r;
        mul_b = magx_r;
      end
      T_SQY: begin
        mul_a = magy_r;
        mul_b = magy_r;
      end
      S2_M0: begin
        mul_a = ex_r;
        mul_b = dx_r;
      end
      S2_M1: begin
        mul_a = ey_r;
        mul_b = dy_r;
      end
      S2_M2: begin
        mul_a = dx_r;
        mul_b = dx_r;
      end
      S2_M3: begin
        mul_a = dy_r;
        mul_b = dy_r;
      end
      G_MUL: begin
        mul_a = {1'b0, quo_r[31:0]};
        mul_b = {2'b00, grid_sp_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // candidate distance
  logic signed [32:0] dfx, dfy;
  logic [32:0]        magx, magy;
  logic [63:0]        d2;
  assign dfx  = 33'(cand_x_r) - 33'(cx_r);
  assign dfy  = 33'(cand_y_r) - 33'(cy_r);
  assign magx = dfx[32] ? 33'(-dfx) : 33'(dfx);
  assign magy = dfy[32] ? 33'(-dfy) : 33'(dfy);
  assign d2   = sqx_r + prod_r[63:0];

  // midpoint, floor of the half sum
  logic signed [32:0] sum_x, sum_y;
  assign sum_x = 33'(ax_r) + 33'(bx_r);
  assign sum_y = 33'(ay_r) + 33'(by_r);

  // divider step
  logic [67:0] rem_sh, rem_nxt;
  logic        q_bit;
  assign rem_sh  = {rem_r[66:0], num_sh_r[33]};
  assign q_bit   = rem_sh >= div_r;
  assign rem_nxt = q_bit ? rem_sh - div_r : rem_sh;

  // projection
  logic [99:0]        proj_num;
  logic signed [32:0] d_sel;
  logic signed [31:0] a_sel;
  logic [33:0]        proj_m;
  logic [33:0]        proj_c;
  assign proj_num = {pacc_r[98:0], 1'b0} + {33'd0, den_r[66:0]};
  assign d_sel    = axis_r ? dy_r : dx_r;
  assign a_sel    = axis_r ? ay_r : ax_r;
  assign proj_m   = {1'b0, quo_r[32:0]};
  assign proj_c   = 34'(a_sel) + (d_sel[32] ? 34'(-proj_m) : proj_m);

  // grid
  logic signed [31:0] g_c;
  logic [31:0]        g_mag;
  logic [32:0]        g_num;
  logic [63:0]        g_r;
  logic signed [31:0] g_out;
  assign g_c   = axis_r ? cy_r : cx_r;
  assign g_mag = g_c[31] ? 32'(-g_c) : 32'(g_c);
  assign g_num = {g_mag, 1'b0} + {2'b00, grid_sp_r};
  assign g_r   = prod_r[63:0];
  always_comb begin
    if (g_c[31]) begin
      g_out = (g_r > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-g_r);
    end else begin
      g_out = (g_r > 64'h7fff_ffff) ? 32'sh7fff_ffff : 32'(g_r);
    end
  end

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      pcount_r    <= '0;
      scount_r    <= '0;
      out_valid_r <= 1'b0;
      snap_en_r   <= 1'b1;
      grid_en_r   <= 1'b0;
      grid_sp_r   <= GRID_SP_RST;
      tol_r       <= TOL_RST;
    end else begin
      prod_r      <= mul_a * mul_b;
      out_valid_r <= 1'b0;

      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_SNAP_EN: snap_en_r <= pwdata[0];
          REG_GRID_EN: grid_en_r <= pwdata[0];
          REG_GRID_SP: grid_sp_r <= pwdata[30:0];
          REG_TOL:     tol_r     <= pwdata[30:0];
          default:     ;
        endcase
      end

      unique case (state_r)
        IDLE: begin
          if (start) begin
            out_x_r      <= '0;
            out_y_r      <= '0;
            out_kind_r   <= KIND_NONE;
            out_status_r <= 1'b0;
            unique case (op_t'(in_op))
              OP_CLEAR: begin
                pcount_r    <= '0;
                scount_r    <= '0;
                out_valid_r <= 1'b1;
              end
              OP_POINT: begin
                if (pfull) out_status_r <= 1'b1;
                else       pcount_r     <= pcount_r + 1'b1;
                out_valid_r <= 1'b1;
              end
              OP_SEGMENT: begin
                if (sfull) out_status_r <= 1'b1;
                else       scount_r     <= scount_r + 1'b1;
                out_valid_r <= 1'b1;
              end
              OP_QUERY: begin
                cx_r       <= in_cursor_x;
                cy_r       <= in_cursor_y;
                res_x_r    <= in_cursor_x;
                res_y_r    <= in_cursor_y;
                res_kind_r <= KIND_NONE;
                if (!snap_en_r) begin
                  out_x_r     <= in_cursor_x;
                  out_y_r     <= in_cursor_y;
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= Q_TOL;
                end
              end
              default: ;
            endcase
          end
        end
        Q_TOL: state_r <= Q_BEST;
        Q_BEST: begin
          best_r  <= prod_r[63:0];
          idx_r   <= '0;
          state_r <= P_RD;
        end
        // loose points
        P_RD: begin
          if (idx_r >= IW'(pcount_r)) begin
            idx_r   <= '0;
            state_r <= S1_RD;
          end else begin
            state_r <= P_LD;
          end
        end
        P_LD: begin
          cand_x_r    <= pt_rdata[63:32];
          cand_y_r    <= pt_rdata[31:0];
          cand_kind_r <= KIND_END;
          idx_r       <= idx_r + 1'b1;
          ret_r       <= P_RD;
          state_r     <= T_DIF;
        end
        // segment start, end, midpoint
        S1_RD: begin
          if (idx_r >= IW'(scount_r)) begin
            idx_r   <= '0;
            state_r <= (res_kind_r == KIND_NONE) ? S2_RD : FIN;
          end else begin
            state_r <= S1_LD;
          end
        end
        S1_LD: begin
          ax_r        <= sa_x;
          ay_r        <= sa_y;
          bx_r        <= sb_x;
          by_r        <= sb_y;
          cand_x_r    <= sa_x;
          cand_y_r    <= sa_y;
          cand_kind_r <= KIND_END;
          idx_r       <= idx_r + 1'b1;
          ret_r       <= S1_B;
          state_r     <= T_DIF;
        end
        S1_B: begin
          cand_x_r    <= bx_r;
          cand_y_r    <= by_r;
          cand_kind_r <= KIND_END;
          ret_r       <= S1_M;
          state_r     <= T_DIF;
        end
        S1_M: begin
          cand_x_r    <= sum_x[32:1];
          cand_y_r    <= sum_y[32:1];
          cand_kind_r <= KIND_MID;
          ret_r       <= S1_RD;
          state_r     <= T_DIF;
        end
        // projection onto segments
        S2_RD: begin
          if (idx_r >= IW'(scount_r)) begin
            if (res_kind_r == KIND_NONE && grid_en_r && grid_sp_r != '0) begin
              axis_r  <= 1'b0;
              state_r <= G_SET;
            end else begin
              state_r <= FIN;
            end
          end else begin
            state_r <= S2_LD;
          end
        end
        S2_LD: begin
          ax_r  <= sa_x;
          ay_r  <= sa_y;
          bx_r  <= sb_x;
          by_r  <= sb_y;
          dx_r  <= 33'(sb_x) - 33'(sa_x);
          dy_r  <= 33'(sb_y) - 33'(sa_y);
          ex_r  <= 33'(cx_r) - 33'(sa_x);
          ey_r  <= 33'(cy_r) - 33'(sa_y);
          idx_r <= idx_r + 1'b1;
          // degenerate segment
          state_r <= (sa_x == sb_x && sa_y == sb_y) ? S2_RD : S2_M0;
        end
        S2_M0: state_r <= S2_M1;
        S2_M1: begin
          n_r     <= 68'(prod_r);
          state_r <= S2_M2;
        end
        S2_M2: begin
          n_r     <= n_r + 68'(prod_r);
          state_r <= S2_M3;
        end
        S2_M3: begin
          den_r   <= 68'(prod_r);
          state_r <= S2_M4;
        end
        S2_M4: begin
          den_r   <= den_r + 68'(prod_r);
          state_r <= S2_DEC;
        end
        S2_DEC: begin
          cand_kind_r <= KIND_SEG;
          ret_r       <= S2_RD;
          if (n_r[67] || n_r == '0) begin
            cand_x_r <= ax_r;
            cand_y_r <= ay_r;
            state_r  <= T_DIF;
          end else if (n_r >= den_r) begin
            cand_x_r <= bx_r;
            cand_y_r <= by_r;
            state_r  <= T_DIF;
          end else begin
            axis_r  <= 1'b0;
            state_r <= PJ_INIT;
          end
        end
        PJ_INIT: begin
          dmag_r  <= d_sel[32] ? 32'(-d_sel) : 32'(d_sel);
          pacc_r  <= '0;
          cnt_r   <= '0;
          state_r <= PJ_MUL;
        end
        PJ_MUL: begin
          pacc_r <= {pacc_r[98:0], 1'b0} + (dmag_r[31] ? {35'd0, n_r[64:0]} : 100'd0);
          dmag_r <= {dmag_r[30:0], 1'b0};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == 6'(MUL_STEPS - 1)) state_r <= PJ_DIV;
        end
        PJ_DIV: begin
          rem_r     <= {2'b00, proj_num[99:34]};
          num_sh_r  <= proj_num[33:0];
          div_r     <= {den_r[66:0], 1'b0};
          quo_r     <= '0;
          cnt_r     <= '0;
          div_ret_r <= PJ_FIN;
          state_r   <= DV_STEP;
        end
        DV_STEP: begin
          rem_r    <= rem_nxt;
          quo_r    <= {quo_r[32:0], q_bit};
          num_sh_r <= {num_sh_r[32:0], 1'b0};
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == 6'(DIV_STEPS - 1)) state_r <= div_ret_r;
        end
        PJ_FIN: begin
          if (!axis_r) begin
            cand_x_r <= proj_c[31:0];
            axis_r   <= 1'b1;
            state_r  <= PJ_INIT;
          end else begin
            cand_y_r <= proj_c[31:0];
            state_r  <= T_DIF;
          end
        end
        // grid rounding, halves away from zero
        G_SET: begin
          rem_r     <= '0;
          num_sh_r  <= {1'b0, g_num};
          div_r     <= {36'd0, grid_sp_r, 1'b0};
          quo_r     <= '0;
          cnt_r     <= '0;
          div_ret_r <= G_MUL;
          state_r   <= DV_STEP;
        end
        G_MUL: state_r <= G_SAT;
        G_SAT: begin
          if (!axis_r) begin
            res_x_r <= g_out;
            axis_r  <= 1'b1;
            state_r <= G_SET;
          end else begin
            res_y_r <= g_out;
            state_r <= FIN;
          end
        end
        // candidate test
        T_DIF: begin
          magx_r  <= magx;
          magy_r  <= magy;
          rej_r   <= (magx >= {2'b00, tol_r}) || (magy >= {2'b00, tol_r});
          state_r <= T_SQX;
        end
        T_SQX: state_r <= rej_r ? ret_r : T_SQY;
        T_SQY: begin
          sqx_r   <= prod_r[63:0];
          state_r <= T_CMP;
        end
        T_CMP: begin
          if (d2 < best_r) begin
            best_r     <= d2;
            res_x_r    <= cand_x_r;
            res_y_r    <= cand_y_r;
            res_kind_r <= cand_kind_r;
          end
          state_r <= ret_r;
        end
        FIN: begin
          out_x_r      <= res_x_r;
          out_y_r      <= res_y_r;
          out_kind_r   <= res_kind_r;
          out_status_r <= 1'b0;
          out_valid_r  <= 1'b1;
          state_r      <= IDLE;
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SNAP_EN: prdata = {31'd0, snap_en_r};
      REG_GRID_EN: prdata = {31'd0, grid_en_r};
      REG_GRID_SP: prdata = {1'b0, grid_sp_r};
      REG_TOL:     prdata = {1'b0, tol_r};
      default:     prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign busy          = state_r != IDLE;
  assign out_valid     = out_valid_r;
  assign out_snap_x    = out_x_r;
  assign out_snap_y    = out_y_r;
  assign out_snap_kind = out_kind_r;
  assign out_status    = out_status_r;

endmodule

### hdl/cps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_checker
// Port-level checks of the point snap engine, bound to the top level.
// ----------------------------------------------------------------------------
module cps_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 in_op,
  input logic                       out_valid,
  input logic signed [31:0]         out_snap_x,
  input logic signed [31:0]         out_snap_y,
  input logic [1:0]                 out_snap_kind,
  input logic                       out_status
);
  import cps_pkg::*;

  // clear and loads answer in the next cycle
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op != OP_QUERY |=> out_valid)
    else $error("load item not answered in one cycle");

  // a result only shows while the engine is free
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // a dropped load carries no position
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |->
      out_snap_x == 32'sd0 && out_snap_y == 32'sd0 && out_snap_kind == KIND_NONE)
    else $error("dropped load with nonzero payload");

  // only a query makes the engine busy
  a_busy_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && $past(in_op) == OP_QUERY)
    else $error("busy without a query");

endmodule

bind cad_point_snap_engine cps_checker u_cps_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_op(in_op),
  .out_valid(out_valid), .out_snap_x(out_snap_x), .out_snap_y(out_snap_y),
  .out_snap_kind(out_snap_kind), .out_status(out_status)
);

### tb/sv/cad_point_snap_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cad_point_snap_engine_checker
// Watches the item, result and register channels of the snap engine. It keeps
// its own copy of the point and segment tables and registers, predicts every
// result, and compares each one in order against what the block returns.
// ----------------------------------------------------------------------------
module cad_point_snap_engine_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic signed [31:0]          in_first_x,
  input  logic signed [31:0]          in_first_y,
  input  logic signed [31:0]          in_second_x,
  input  logic signed [31:0]          in_second_y,
  input  logic signed [31:0]          in_cursor_x,
  input  logic signed [31:0]          in_cursor_y,
  input  logic                        out_valid,
  input  logic signed [31:0]          out_snap_x,
  input  logic signed [31:0]          out_snap_y,
  input  logic [1:0]                  out_snap_kind,
  input  logic                        out_status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [cps_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output int                          errors,
  output int                          outstanding
);
  import cps_pkg::*;

  localparam int TABLE_DEPTH = 64;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    kind_t              kind;
    logic               status;
  } snap_res_t;

  snap_res_t snap_q[$];

  longint pt_x[TABLE_DEPTH], pt_y[TABLE_DEPTH];
  longint sa_x[TABLE_DEPTH], sa_y[TABLE_DEPTH];
  longint sb_x[TABLE_DEPTH], sb_y[TABLE_DEPTH];
  int     pt_cnt, seg_cnt;

  logic        snap_en_r, grid_en_r;
  logic [30:0] grid_sp_r, tol_r;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  // strictly nearer than best and inside the per-axis capture box
  function automatic bit try_near(longint px, longint py, longint cx, longint cy,
                                  inout longint unsigned best);
    longint            ax, ay;
    longint unsigned   d2;
    ax = px - cx;
    ay = py - cy;
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    if (ax >= longint'(tol_r) || ay >= longint'(tol_r)) return 1'b0;
    d2 = ax * ax + ay * ay;
    if (d2 < best) begin
      best = d2;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // a + d*n/den, quotient rounded half away from zero
  function automatic longint proj_axis(longint a, longint d, logic [127:0] n,
                                       logic [127:0] den);
    logic [127:0] mag, num, q;
    longint       m;
    mag = (d < 0) ? -d : d;
    num = ((n * mag) << 1) + den;
    q   = num / (den << 1);
    m   = longint'(q[63:0]);
    return (d < 0) ? a - m : a + m;
  endfunction

  function automatic longint grid_round(longint c);
    longint unsigned g, m, q, r;
    g = grid_sp_r;
    if (g == 0) return c;
    m = (c < 0) ? -c : c;
    q = (2 * m + g) / (2 * g);
    r = q * g;
    if (c < 0)
      return (r > 64'd2147483648) ? -longint'(64'd2147483648) : -longint'(r);
    return (r > 64'd2147483647) ? longint'(64'd2147483647) : longint'(r);
  endfunction

  function automatic snap_res_t run_query(longint cx, longint cy);
    snap_res_t          res;
    longint unsigned    best;
    longint             rx, ry, mx, my, dx, dy, nx, ny;
    logic signed [127:0] ex, ey, wdx, wdy, n, den;
    kind_t              kind;
    best = longint'(tol_r) * longint'(tol_r);
    rx   = cx;
    ry   = cy;
    kind = KIND_NONE;
    if (snap_en_r) begin
      for (int i = 0; i < pt_cnt; i++)
        if (try_near(pt_x[i], pt_y[i], cx, cy, best)) begin
          rx = pt_x[i]; ry = pt_y[i]; kind = KIND_END;
        end
      for (int i = 0; i < seg_cnt; i++) begin
        mx = (sa_x[i] + sb_x[i]) >>> 1;
        my = (sa_y[i] + sb_y[i]) >>> 1;
        if (try_near(sa_x[i], sa_y[i], cx, cy, best)) begin
          rx = sa_x[i]; ry = sa_y[i]; kind = KIND_END;
        end
        if (try_near(sb_x[i], sb_y[i], cx, cy, best)) begin
          rx = sb_x[i]; ry = sb_y[i]; kind = KIND_END;
        end
        if (try_near(mx, my, cx, cy, best)) begin
          rx = mx; ry = my; kind = KIND_MID;
        end
      end
      if (kind == KIND_NONE) begin
        for (int i = 0; i < seg_cnt; i++) begin
          dx = sb_x[i] - sa_x[i];
          dy = sb_y[i] - sa_y[i];
          if (dx != 0 || dy != 0) begin
            ex  = cx - sa_x[i];
            ey  = cy - sa_y[i];
            wdx = dx;
            wdy = dy;
            n   = ex * wdx + ey * wdy;
            den = wdx * wdx + wdy * wdy;
            if (n <= 0) begin
              nx = sa_x[i]; ny = sa_y[i];
            end else if (n >= den) begin
              nx = sb_x[i]; ny = sb_y[i];
            end else begin
              nx = proj_axis(sa_x[i], dx, n, den);
              ny = proj_axis(sa_y[i], dy, n, den);
            end
            if (try_near(nx, ny, cx, cy, best)) begin
              rx = nx; ry = ny; kind = KIND_SEG;
            end
          end
        end
      end
      if (kind == KIND_NONE && grid_en_r) begin
        rx = grid_round(cx);
        ry = grid_round(cy);
      end
    end
    res.x      = rx[31:0];
    res.y      = ry[31:0];
    res.kind   = kind;
    res.status = 1'b0;
    return res;
  endfunction

  function automatic snap_res_t predict_snap();
    snap_res_t res;
    res = '{x: '0, y: '0, kind: KIND_NONE, status: 1'b0};
    case (op_t'(in_op))
      OP_CLEAR: begin
        pt_cnt  = 0;
        seg_cnt = 0;
      end
      OP_POINT: begin
        if (pt_cnt >= TABLE_DEPTH) res.status = 1'b1;
        else begin
          pt_x[pt_cnt] = in_first_x;
          pt_y[pt_cnt] = in_first_y;
          pt_cnt++;
        end
      end
      OP_SEGMENT: begin
        if (seg_cnt >= TABLE_DEPTH) res.status = 1'b1;
        else begin
          sa_x[seg_cnt] = in_first_x;
          sa_y[seg_cnt] = in_first_y;
          sb_x[seg_cnt] = in_second_x;
          sb_y[seg_cnt] = in_second_y;
          seg_cnt++;
        end
      end
      default: res = run_query(in_cursor_x, in_cursor_y);
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    snap_res_t want;
    if (!rst_n) begin
      pt_cnt    <= 0;
      seg_cnt   <= 0;
      snap_en_r <= 1'b1;
      grid_en_r <= 1'b0;
      grid_sp_r <= GRID_SP_RST;
      tol_r     <= TOL_RST;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SNAP_EN: snap_en_r <= pwdata[0];
          REG_GRID_EN: grid_en_r <= pwdata[0];
          REG_GRID_SP: grid_sp_r <= pwdata[30:0];
          REG_TOL:     tol_r     <= pwdata[30:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (snap_q.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h kind=%0d status=%0d", $time,
                   out_snap_x, out_snap_y, out_snap_kind, out_status);
          errors++;
        end else begin
          want = snap_q.pop_front();
          if (out_snap_x !== want.x || out_snap_y !== want.y ||
              out_snap_kind !== want.kind || out_status !== want.status) begin
            $display("%0t: mismatch expected x=%h y=%h kind=%0d status=%0d", $time,
                     want.x, want.y, want.kind, want.status);
            $display("%0t:          actual   x=%h y=%h kind=%0d status=%0d", $time,
                     out_snap_x, out_snap_y, out_snap_kind, out_status);
            errors++;
          end
        end
      end
      if (start && !busy) snap_q.push_back(predict_snap());
      outstanding <= snap_q.size();
    end
  end

endmodule

### tb/sv/cad_point_snap_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cad_point_snap_engine_test
// Drives directed and random load/query traffic and register settings into the
// snap engine; the checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module cad_point_snap_engine_test;
  import cps_pkg::*;

  localparam int  N_RANDOM    = 780;
  localparam longint MAX_CYCLES = 50000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_op = OP_CLEAR;
  logic signed [31:0] in_first_x = '0, in_first_y = '0;
  logic signed [31:0] in_second_x = '0, in_second_y = '0;
  logic signed [31:0] in_cursor_x = '0, in_cursor_y = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;

  logic busy, out_valid, out_status, pready;
  logic signed [31:0] out_snap_x, out_snap_y;
  logic [1:0] out_snap_kind;
  logic [31:0] prdata;
  int errors, outstanding;

  bit     idle_on = 1'b1;
  longint cycle_cnt = 0;
  int     items_sent = 0;
  logic [30:0] cur_tol = TOL_RST;

  always #4 clk = ~clk;

  cad_point_snap_engine u_dut (
    .clk, .rst_n, .start, .busy, .in_op, .in_first_x, .in_first_y,
    .in_second_x, .in_second_y, .in_cursor_x, .in_cursor_y, .out_valid,
    .out_snap_x, .out_snap_y, .out_snap_kind, .out_status,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  cad_point_snap_engine_checker u_chk (
    .clk, .rst_n, .start, .busy, .in_op, .in_first_x, .in_first_y,
    .in_second_x, .in_second_y, .in_cursor_x, .in_cursor_y, .out_valid,
    .out_snap_x, .out_snap_y, .out_snap_kind, .out_status,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .outstanding
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("cad_point_snap_engine_test: FAIL");
      $finish;
    end
  end

  // returns right after the edge that takes the item; start left high
  task automatic send(op_t op, logic [31:0] fx, logic [31:0] fy, logic [31:0] sx,
                      logic [31:0] sy, logic [31:0] cx, logic [31:0] cy);
    while (idle_on && $urandom_range(0, 99) < 32) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_op       <= op;
    in_first_x  <= fx;
    in_first_y  <= fy;
    in_second_x <= sx;
    in_second_y <= sy;
    in_cursor_x <= cx;
    in_cursor_y <= cy;
    do @(negedge clk); while (busy);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic query(logic [31:0] cx, logic [31:0] cy);
    send(OP_QUERY, $urandom, $urandom, $urandom, $urandom, cx, cy);
  endtask

  task automatic add_point(logic [31:0] x, logic [31:0] y);
    send(OP_POINT, x, y, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic add_seg(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                         logic [31:0] by);
    send(OP_SEGMENT, ax, ay, bx, by, $urandom, $urandom);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0 || busy);
    @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_TOL) cur_tol = val[30:0];
  endtask

  function automatic logic [31:0] near(logic [31:0] base, longint spread);
    longint off;
    off = longint'($urandom_range(0, 32'(2 * spread))) - spread;
    return base + off[31:0];
  endfunction

  task automatic random_config();
    int sel;
    reg_write(REG_SNAP_EN, ($urandom_range(0, 9) != 0) ? 32'd1 : 32'd0);
    reg_write(REG_GRID_EN, $urandom);
    sel = $urandom_range(0, 5);
    case (sel)
      0: reg_write(REG_GRID_SP, 32'd1);
      1: reg_write(REG_GRID_SP, 32'h7fffffff);
      2: reg_write(REG_GRID_SP, 32'd65536);
      3: reg_write(REG_GRID_SP, 32'd0);
      default: reg_write(REG_GRID_SP, $urandom_range(1, 32'h00ffffff));
    endcase
    sel = $urandom_range(0, 7);
    case (sel)
      0: reg_write(REG_TOL, 32'd0);
      1: reg_write(REG_TOL, 32'h7fffffff);
      2: reg_write(REG_TOL, 32'd1);
      3: reg_write(REG_TOL, {$urandom} | 32'h80000000);
      default: reg_write(REG_TOL, $urandom_range(16, 32'h00200000));
    endcase
  endtask

  // an optional clear and a cluster of loads around one spot, then queries near it
  task automatic cluster();
    logic [31:0] base_x, base_y, ax, ay;
    longint spread;
    int sel;
    sel = $urandom_range(0, 9);
    base_x = (sel == 0) ? 32'h7fffff00 : (sel == 1) ? 32'h80000100 : $urandom;
    base_y = (sel == 2) ? 32'h80000000 : $urandom;
    case ($urandom_range(0, 3))
      0: spread = 64;
      1: spread = longint'(cur_tol) / 2 + 1;
      2: spread = longint'(cur_tol) * 2 + 1;
      default: spread = 32'h000fffff;
    endcase
    if (spread > 32'h3fffffff) spread = 32'h3fffffff;
    if ($urandom_range(0, 3) == 0) send(OP_CLEAR, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom);
    repeat ($urandom_range(0, 4)) add_point(near(base_x, spread), near(base_y, spread));
    repeat ($urandom_range(0, 3)) begin
      ax = near(base_x, spread);
      ay = near(base_y, spread);
      if ($urandom_range(0, 7) == 0) add_seg(ax, ay, ax, ay);
      else add_seg(ax, ay, near(base_x, spread), near(base_y, spread));
    end
    repeat ($urandom_range(1, 6)) query(near(base_x, spread), near(base_y, spread));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, empty tables, extremes
    query(32'h80000000, 32'h7fffffff);
    add_point(32'd0, 32'd0);
    add_point(32'h7fffffff, 32'h80000000);
    query(32'd100, -32'sd50);
    query(32'h7ffffff0, 32'h80000010);
    add_seg(32'd40 << 16, 32'd0, 32'd60 << 16, 32'd0);
    query((32'd50 << 16) + 5, 32'd3);
    query(32'd45 << 16, 32'd7 << 16);
    add_seg(32'd100 << 16, 32'd0, 32'd300 << 16, 32'd0);
    query(32'd150 << 16, 32'd3 << 16);
    add_seg(-32'sd5 << 16, -32'sd5 << 16, -32'sd5 << 16, -32'sd5 << 16);
    add_seg(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    query(32'd1000 << 8, -32'sd1000 << 8);
    drain();
    reg_write(REG_TOL, 32'd0);
    query(32'd0, 32'd0);
    drain();
    reg_write(REG_GRID_EN, 32'd1);
    reg_write(REG_GRID_SP, 32'd3 << 16);
    query(-32'sd294912, 32'd229376);
    drain();
    reg_write(REG_GRID_SP, 32'd0);
    query(32'd12345, -32'sd12345);
    drain();
    reg_write(REG_GRID_SP, 32'h7fffffff);
    query(32'h80000000, 32'h7fffffff);
    query(32'hc0000000, 32'h40000000);
    drain();
    reg_write(REG_SNAP_EN, 32'd0);
    query(32'd0, 32'd0);
    drain();
    reg_write(REG_SNAP_EN, 32'd1);
    reg_write(REG_GRID_EN, 32'd0);
    reg_write(REG_GRID_SP, 32'd65536);
    reg_write(REG_TOL, 32'h7fffffff);
    query(32'h40000000, 32'hc0000000);
    send(OP_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
         32'hffffffff, 32'hffffffff);
    query(32'd0, 32'd0);
    drain();
    reg_write(REG_TOL, TOL_RST);

    // random phases
    while (items_sent < N_RANDOM) begin
      if ($urandom_range(0, 99) < 15) begin
        send(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom);
      end else begin
        cluster();
      end
      idle_on = !(items_sent > 300 && items_sent < 450);
      if ($urandom_range(0, 29) == 0) begin
        drain();
        random_config();
      end
      if (items_sent > 500 && items_sent < 520) begin
        // overflow both tables, then query with them full
        send(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        repeat (66) add_point(near(32'd0, 32'h00400000), near(32'd0, 32'h00400000));
        repeat (66) add_seg(near(32'd0, 32'h00400000), near(32'd0, 32'h00400000),
                            near(32'd0, 32'h00400000), near(32'd0, 32'h00400000));
        repeat (2) query(near(32'd0, 32'h00400000), near(32'd0, 32'h00400000));
        send(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("cad_point_snap_engine_test: PASS");
    end else begin
      $display("cad_point_snap_engine_test: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/cps_pkg.sv
hdl/cps_ram.sv
hdl/cad_point_snap_engine.sv
hdl/cps_checker.sv
tb/sv/cad_point_snap_engine_checker.sv
tb/sv/cad_point_snap_engine_test.sv
